// ===== src/websocket_frame_deframer_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the WebSocket frame deframer.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define WSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== src/wsd_pkg.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Shared parse phase type, result bundle and header constants.
// ---------------------------------------------------------------------------
package wsd_pkg;

  // Parse phase, one-hot coded.
  typedef enum logic [6:0] {
    PH_HDR     = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_EXT16   = 7'b0000100,
    PH_EXT64   = 7'b0001000,
    PH_MASK    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DEAD    = 7'b1000000
  } phase_e;

  // Seven-bit length code that selects the 16-bit extended length.
  localparam logic [6:0] LenExt16 = 7'd126;
  // Header byte counter value on the last byte of each header field.
  localparam logic [2:0] Ext16Last = 3'd1;
  localparam logic [2:0] Ext64Last = 3'd7;
  localparam logic [2:0] MaskLast  = 3'd3;

  // One result beat as produced by the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_byte;
    logic       empty_frame;
    logic       unmasked_error;
  } result_t;

endpackage

// ===== src/wsd_parse.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer parser
// Holds the frame parse state and turns one received byte into at most one
// combinational result.
// ---------------------------------------------------------------------------
module wsd_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  output wsd_pkg::result_t res_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  hc_q, hc_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;
  logic [3:0]  op_q, op_d;
  logic        fin_q, fin_d;

  logic [7:0]  key_byte;
  logic [2:0]  ext_last;

  // Mask byte for the current payload index; the first mask byte sits on top.
  always_comb begin
    unique case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign ext_last = (phase_q == PH_EXT16) ? Ext16Last : Ext64Last;

  // Next state and result for one byte.
  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    key_d   = key_q;
    idx_d   = idx_q;
    op_d    = op_q;
    fin_d   = fin_q;

    res_o                = '0;
    res_o.frame_opcode   = op_q;
    res_o.final_fragment = fin_q;

    if (step_i) begin
      unique case (phase_q)
        PH_HDR: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          // Bit 7 is the mask bit; a client frame without it is fatal.
          if (!rx_byte_i[7]) begin
            phase_d              = PH_DEAD;
            res_o.valid          = 1'b1;
            res_o.unmasked_error = 1'b1;
          end else begin
            hc_d  = '0;
            acc_d = '0;
            key_d = '0;
            if (rx_byte_i[6:0] < LenExt16) begin
              rem_d   = {57'd0, rx_byte_i[6:0]};
              phase_d = PH_MASK;
            end else if (rx_byte_i[6:0] == LenExt16) begin
              phase_d = PH_EXT16;
            end else begin
              phase_d = PH_EXT64;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          // Extended length arrives big-endian.
          acc_d = {acc_q[55:0], rx_byte_i};
          if (hc_q == ext_last) begin
            rem_d   = {acc_q[55:0], rx_byte_i};
            hc_d    = '0;
            phase_d = PH_MASK;
          end else begin
            hc_d = hc_q + 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (hc_q >= MaskLast) begin
            hc_d  = '0;
            idx_d = '0;
            if (rem_q == 64'd0) begin
              phase_d           = PH_HDR;
              res_o.valid       = 1'b1;
              res_o.empty_frame = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            hc_d = hc_q + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          res_o.valid        = 1'b1;
          res_o.payload_byte = rx_byte_i ^ key_byte;
          res_o.last_byte    = (rem_q == 64'd1);
          idx_d              = idx_q + 2'd1;
          rem_d              = rem_q - 64'd1;
          if (rem_q == 64'd1) begin
            phase_d = PH_HDR;
          end
        end
        PH_DEAD: begin
          phase_d = PH_DEAD;
        end
        default: begin
          phase_d = PH_HDR;
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      hc_q    <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      idx_q   <= '0;
      op_q    <= '0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
      op_q    <= op_d;
      fin_q   <= fin_d;
    end
  end

  `include "websocket_frame_deframer_core_assert.svh"

  // Once an unmasked frame is seen the parser never leaves the dead phase.
  `WSD_ASSERT_NEXT(a_dead_sticky, phase_q == PH_DEAD, phase_q == PH_DEAD)
  // An error result only comes out of the length byte.
  `WSD_ASSERT_IMPL(a_err_on_len, res_o.valid && res_o.unmasked_error, phase_q == PH_LEN)
  // Payload phase always has at least one byte left to deliver.
  `WSD_ASSERT_IMPL(a_payload_nonzero, phase_q == PH_PAYLOAD, rem_q != 64'd0)
  // The mask byte counter never passes the fourth mask byte.
  `WSD_ASSERT_IMPL(a_mask_count, phase_q == PH_MASK, hc_q <= MaskLast)

endmodule

// ===== src/wsd_out_reg.sv =====
// ---------------------------------------------------------------------------
// WebSocket deframer output register
// Holds one result beat until the downstream side takes it.
// ---------------------------------------------------------------------------
module wsd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  wsd_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             advance_o,
  output logic             out_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic [3:0]       frame_opcode_o,
  output logic             final_fragment_o,
  output logic             last_byte_o,
  output logic             empty_frame_o,
  output logic             unmasked_error_o
);
  import wsd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // The register can take a new beat when it is empty or being drained.
  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? (step_i && res_i.valid) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload fields load only with a new result beat.
  always_ff @(posedge clk_i) begin
    if (step_i && res_i.valid && advance_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign payload_byte_o   = data_q.payload_byte;
  assign frame_opcode_o   = data_q.frame_opcode;
  assign final_fragment_o = data_q.final_fragment;
  assign last_byte_o      = data_q.last_byte;
  assign empty_frame_o    = data_q.empty_frame;
  assign unmasked_error_o = data_q.unmasked_error;

endmodule

// ===== src/websocket_frame_deframer_core.sv =====
// ---------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses masked client-to-server frames from a byte stream and delivers the
// unmasked payload bytes, empty-frame marks and unmasked-frame errors.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   rx_byte_i
//  out      output     out_valid_o/out_stall_i payload_byte_o, frame_opcode_o,
//                                              final_fragment_o, last_byte_o,
//                                              empty_frame_o, unmasked_error_o
//
// One byte per cycle unless the output stalls; a stall holds the output
// register and backs up through the input register to in_stall_o in the same
// cycle. A byte's result passes from the input register through the parse
// logic into the output register. The rate is set by the combinational parse
// step, whose deepest path is the 64-bit remaining-length decrement and
// compare. Reset clears the parse state to wait for a frame's first byte; no
// clearing pass is needed. Header and mask bytes give no output beat, save an
// unmasked-frame error on the length byte and an empty-frame mark.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       final_fragment_o,
  output logic       last_byte_o,
  output logic       empty_frame_o,
  output logic       unmasked_error_o
);
  import wsd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       step;
  result_t    res;

  // The buffered byte is parsed when the output register can take its result.
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame parser.
  wsd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  // Result register.
  wsd_out_reg u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .res_i            (res),
    .out_stall_i      (out_stall_i),
    .advance_o        (advance),
    .out_valid_o      (out_valid_o),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .last_byte_o      (last_byte_o),
    .empty_frame_o    (empty_frame_o),
    .unmasked_error_o (unmasked_error_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// Testbench for the WebSocket frame deframer core
// Streams masked client frames into the parser byte by byte, predicts every
// output beat with a behavioral parser, and compares beats field by field
// under phases of sender idling, receiver stalling and a long output hold.
// ---------------------------------------------------------------------------
module tb_top;
  import wsd_pkg::*;

  // Idle pattern carried by each stimulus byte.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // Length encodings of the second header byte.
  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_kind_e;

  typedef struct {
    logic [7:0] data;
    idle_mode_e mode;
  } stim_t;

  localparam logic [7:0] MASK_BIT   = 8'h80;
  localparam logic [7:0] LEN_CODE16 = {1'b1, LenExt16};
  localparam logic [7:0] LEN_CODE64 = 8'hFF;
  localparam int PRESSURE_AT    = 200;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 270;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic [3:0] frame_opcode_o;
  logic       final_fragment_o;
  logic       last_byte_o;
  logic       empty_frame_o;
  logic       unmasked_error_o;

  websocket_frame_deframer_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .last_byte_o      (last_byte_o),
    .empty_frame_o    (empty_frame_o),
    .unmasked_error_o (unmasked_error_o)
  );

  stim_t      byte_stream_q[$];
  result_t    unmasked_q[$];
  idle_mode_e cur_mode = IDLE_NONE;
  int         total_items;
  int         accepted_in = 0;
  int         beats_seen = 0;
  int         beats_payload = 0;
  int         beats_empty = 0;
  int         beats_error = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  string      tail_note;

  // Parser state of the predictor, at its reset values.
  phase_e      parse_at   = PH_HDR;
  logic [2:0]  hdr_cnt    = '0;
  logic [63:0] len_acc    = '0;
  logic [63:0] bytes_left = '0;
  logic [31:0] mask_word  = '0;
  logic [1:0]  key_idx    = '0;
  logic [3:0]  cur_opcode = '0;
  logic        cur_fin    = 1'b0;
  logic        dead       = 1'b0;

  // Clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queue one expected beat tagged with the current frame's opcode and FIN.
  task automatic push_beat(input logic [7:0] pay, input logic last, input logic empty,
                           input logic err);
    result_t r;
    r.valid          = 1'b1;
    r.payload_byte   = pay;
    r.frame_opcode   = cur_opcode;
    r.final_fragment = cur_fin;
    r.last_byte      = last;
    r.empty_frame    = empty;
    r.unmasked_error = err;
    unmasked_q.push_back(r);
    if (err) beats_error++;
    else if (empty) beats_empty++;
    else beats_payload++;
  endtask

  // Advance the predicted parser by one accepted byte.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key;
    logic       last;
    if (dead) begin
      parse_at = PH_DEAD;
    end else begin
      case (parse_at)
        PH_LEN: begin
          if (!b[7]) begin
            // Unmasked frame: report once and go dead until reset.
            dead     = 1'b1;
            parse_at = PH_DEAD;
            push_beat(8'h00, 1'b0, 1'b0, 1'b1);
          end else begin
            hdr_cnt   = '0;
            len_acc   = '0;
            mask_word = '0;
            if (b[6:0] < LenExt16) begin
              bytes_left = 64'(b[6:0]);
              parse_at   = PH_MASK;
            end else if (b[6:0] == LenExt16) begin
              parse_at = PH_EXT16;
            end else begin
              parse_at = PH_EXT64;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_acc = {len_acc[55:0], b};
          if (hdr_cnt == ((parse_at == PH_EXT16) ? Ext16Last : Ext64Last)) begin
            bytes_left = len_acc;
            hdr_cnt    = '0;
            parse_at   = PH_MASK;
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        PH_MASK: begin
          mask_word = {mask_word[23:0], b};
          if (hdr_cnt >= MaskLast) begin
            hdr_cnt = '0;
            key_idx = '0;
            if (bytes_left == 64'd0) begin
              parse_at = PH_HDR;
              push_beat(8'h00, 1'b0, 1'b1, 1'b0);
            end else begin
              parse_at = PH_PAYLOAD;
            end
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          key        = mask_word[8 * (3 - int'(key_idx)) +: 8];
          last       = (bytes_left == 64'd1);
          key_idx    = key_idx + 2'd1;
          bytes_left = bytes_left - 64'd1;
          if (last) parse_at = PH_HDR;
          push_beat(b ^ key, last, 1'b0, 1'b0);
        end
        default: begin
          cur_fin    = b[7];
          cur_opcode = b[3:0];
          parse_at   = PH_LEN;
        end
      endcase
    end
  endtask

  task automatic add_byte(input logic [7:0] data, input idle_mode_e mode);
    stim_t s;
    s.data = data;
    s.mode = mode;
    byte_stream_q.push_back(s);
  endtask

  // Queue a masked frame header and random mask, then body payload bytes.
  task automatic add_frame(input logic [7:0] first, input len_kind_e kind,
                           input logic [63:0] len, input int body, input idle_mode_e mode);
    add_byte(first, mode);
    case (kind)
      LEN_SHORT: add_byte(MASK_BIT | {1'b0, len[6:0]}, mode);
      LEN_EXT16: begin
        add_byte(LEN_CODE16, mode);
        add_byte(len[15:8], mode);
        add_byte(len[7:0], mode);
      end
      default: begin
        add_byte(LEN_CODE64, mode);
        for (int i = 7; i >= 0; i--) add_byte(len[8 * i +: 8], mode);
      end
    endcase
    repeat (4) add_byte(8'($urandom_range(0, 255)), mode);
    for (int i = 0; i < body; i++) add_byte(8'($urandom_range(0, 255)), mode);
  endtask

  // Well-formed frame with mostly short payloads and any length encoding.
  task automatic add_random_frame(input idle_mode_e mode);
    int          pick;
    logic [63:0] len;
    len_kind_e   kind;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 64'd0;
    else if (pick < 60) len = 64'($urandom_range(1, 8));
    else if (pick < 85) len = 64'($urandom_range(9, 40));
    else len = 64'($urandom_range(41, 125));
    pick = $urandom_range(0, 9);
    kind = (pick < 7) ? LEN_SHORT : (pick < 9) ? LEN_EXT16 : LEN_EXT64;
    if (kind != LEN_SHORT && $urandom_range(0, 3) == 0) len = 64'($urandom_range(126, 300));
    add_frame(8'($urandom_range(0, 255)), kind, len, int'(len), mode);
  endtask

  task automatic add_phase(input idle_mode_e mode);
    int target;
    target = byte_stream_q.size() + PHASE_ITEMS;
    while (byte_stream_q.size() < target) add_random_frame(mode);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [7:0]  opening[$];
    logic [63:0] huge_len;
    rst_ni      = 1'b0;

    // Reserved bits set with a five-byte payload that wraps the mask index,
    // a zero-length frame with FIN and the top opcode, and a one-byte frame
    // behind a 16-bit extended length.
    opening = '{8'h70, MASK_BIT | 8'd5, 8'h00, 8'hFF, 8'hA5, 8'h5A,
                8'hFF, 8'h00, 8'h12, 8'h34, 8'hFF,
                8'h8F, MASK_BIT, 8'h11, 8'h22, 8'h33, 8'h44,
                8'h01, LEN_CODE16, 8'h00, 8'h01, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h80};
    foreach (opening[i]) add_byte(opening[i], IDLE_NONE);

    // Longest 7-bit length, and a 64-bit extended length of zero.
    add_frame(8'h82, LEN_SHORT, 64'd125, 125, IDLE_NONE);
    add_frame(8'h09, LEN_EXT64, 64'd0, 0, IDLE_NONE);
    add_phase(IDLE_NONE);
    add_phase(IDLE_SEND);
    add_phase(IDLE_RECV);
    add_phase(IDLE_BOTH);

    // The stream can end in only one of two ways: an unmasked frame kills the
    // parser, and a length with bit 63 set never completes.
    if ($urandom_range(0, 2) != 0) begin
      tail_note = "unmasked frame then dropped bytes";
      add_byte(8'($urandom_range(0, 255)), IDLE_BOTH);
      add_byte(8'($urandom_range(0, 127)), IDLE_BOTH);
      repeat (6) add_byte(8'($urandom_range(0, 255)), IDLE_BOTH);
    end else begin
      tail_note = "64-bit length with the top bit set";
      huge_len = {1'b1, 31'($urandom()), 32'($urandom())};
      add_frame(8'($urandom_range(0, 255)), LEN_EXT64, huge_len, 24, IDLE_BOTH);
    end
    total_items = byte_stream_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_in != total_items) @(negedge clk_i);
    while (unmasked_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Streamed %0d bytes; checked %0d beats: %0d payload, %0d empty frame, %0d error.",
             accepted_in, beats_seen, beats_payload, beats_empty, beats_error);
    $display("Stream ended with a %s; %0d field mismatches.", tail_note, mismatches);
    if (mismatches == 0) begin
      $display("websocket_frame_deframer_core: match");
    end else begin
      $display("websocket_frame_deframer_core: mismatch");
    end
    $finish;
  end

  // Input driver: holds each byte until it is taken, with gaps per its phase.
  always @(posedge clk_i) begin : driver
    stim_t nxt;
    logic  offer;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      offer = 1'b0;
      if (byte_stream_q.size() != 0) begin
        nxt = byte_stream_q[0];
        case (nxt.mode)
          IDLE_SEND: offer = ($urandom_range(0, 99) >= 58);
          IDLE_BOTH: offer = ($urandom_range(0, 99) >= 18);
          default:   offer = 1'b1;
        endcase
        if (offer) begin
          void'(byte_stream_q.pop_front());
          rx_byte_i <= nxt.data;
          cur_mode  <= nxt.mode;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Output stall: random per phase, plus one long hold while bytes keep coming.
  always @(posedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && accepted_in >= PRESSURE_AT) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
      end else begin
        case (cur_mode)
          IDLE_RECV: out_stall_i <= ($urandom_range(0, 99) < 58);
          IDLE_BOTH: out_stall_i <= ($urandom_range(0, 99) < 18);
          default:   out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Monitor: checks each output beat, predicts from each input beat, and
  // ends the run if no beat moves for too long.
  always @(posedge clk_i) begin : monitor
    result_t want;
    logic    moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        beats_seen++;
        if (unmasked_q.size() == 0) begin
          mismatches++;
          $display("%0t: expected no beat, got byte %h opcode %h fin %b last %b",
                   $time, payload_byte_o, frame_opcode_o, final_fragment_o, last_byte_o);
          $display("%0t: expected no beat, got empty %b error %b",
                   $time, empty_frame_o, unmasked_error_o);
        end else begin
          want = unmasked_q.pop_front();
          check_field("payload_byte", want.payload_byte, payload_byte_o);
          check_field("frame_opcode", 8'(want.frame_opcode), 8'(frame_opcode_o));
          check_field("final_fragment", 8'(want.final_fragment), 8'(final_fragment_o));
          check_field("last_byte", 8'(want.last_byte), 8'(last_byte_o));
          check_field("empty_frame", 8'(want.empty_frame), 8'(empty_frame_o));
          check_field("unmasked_error", 8'(want.unmasked_error), 8'(unmasked_error_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        accepted_in <= accepted_in + 1;
        deframe_byte(rx_byte_i);
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d of %0d bytes taken, %0d beats owed",
                 $time, idle_cycles, accepted_in, total_items, unmasked_q.size());
        $display("websocket_frame_deframer_core: mismatch");
        $finish;
      end
    end
  end

endmodule
